FILE: design/cna_pkg.sv
`timescale 1ns / 1ps

package cna_pkg;

    localparam int FRAC_BITS = 8;
    localparam int OP_W      = 16;
    localparam int PROD_W    = 2 * OP_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam int MAG_W     = PROD_W;
    localparam int NUM_W     = MAG_W + FRAC_BITS;
    localparam int QT_W      = OP_W;
    localparam int CMP_W     = MAG_W + QT_W;
    localparam int STEP_W    = $clog2(QT_W);
    localparam int CLAMP_W   = SUM_W + 1;

    typedef enum logic [2:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_DIV = 3'd3,
        CMD_EQ  = 3'd4,
        CMD_NE  = 3'd5,
        CMD_GT  = 3'd6,
        CMD_LT  = 3'd7
    } t_cmd;

    // per-item info that rides alongside the divider
    typedef struct packed {
        logic            is_div;
        logic            dz;
        logic            neg_re;
        logic            neg_im;
        logic [OP_W-1:0] re;
        logic [OP_W-1:0] im;
        logic            cmp;
        logic            sat;
        logic            ovf_re;
        logic            ovf_im;
    } t_side;

    typedef struct packed {
        t_side            side;
        logic [NUM_W-1:0] rem_re;
        logic [NUM_W-1:0] rem_im;
        logic [QT_W-1:0]  q_re;
        logic [QT_W-1:0]  q_im;
        logic [MAG_W-1:0] divisor;
    } t_div_state;

    // clamp to the signed result range; returns {sat, value}
    function automatic logic [OP_W:0] clamp_q(input logic signed [CLAMP_W-1:0] v);
        logic signed [CLAMP_W-1:0] hi;
        logic signed [CLAMP_W-1:0] lo;
        logic [OP_W:0]             r;
        hi = CLAMP_W'(signed'({1'b0, {(OP_W-1){1'b1}}}));
        lo = CLAMP_W'(signed'({1'b1, {(OP_W-1){1'b0}}}));
        if (v > hi) begin
            r = {1'b1, hi[OP_W-1:0]};
        end else if (v < lo) begin
            r = {1'b1, lo[OP_W-1:0]};
        end else begin
            r = {1'b0, v[OP_W-1:0]};
        end
        return r;
    endfunction

endpackage

FILE: design/cna_prep.sv
`timescale 1ns / 1ps

module cna_prep (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [2:0]                    i_cmd,
    input  logic signed [cna_pkg::OP_W-1:0] i_left_real,
    input  logic signed [cna_pkg::OP_W-1:0] i_left_imag,
    input  logic signed [cna_pkg::OP_W-1:0] i_right_real,
    input  logic signed [cna_pkg::OP_W-1:0] i_right_imag,
    output logic                          o_valid,
    output cna_pkg::t_div_state           o_state
);
    import cna_pkg::*;

    // stage 1: products, add/sub, equality
    logic                     r1_valid;
    t_cmd                     r1_cmd;
    logic signed [PROD_W-1:0] r1_p_rr, r1_p_ii, r1_p_ri, r1_p_ir;
    logic signed [PROD_W-1:0] r1_p_lr, r1_p_li, r1_p_mr, r1_p_mi;
    logic signed [OP_W:0]     r1_as_re, r1_as_im;
    logic                     r1_eq;
    logic signed [OP_W:0]     n1_as_re, n1_as_im;

    always_comb begin
        if (t_cmd'(i_cmd) == CMD_SUB) begin
            n1_as_re = {i_left_real[OP_W-1], i_left_real} - {i_right_real[OP_W-1], i_right_real};
            n1_as_im = {i_left_imag[OP_W-1], i_left_imag} - {i_right_imag[OP_W-1], i_right_imag};
        end else begin
            n1_as_re = {i_left_real[OP_W-1], i_left_real} + {i_right_real[OP_W-1], i_right_real};
            n1_as_im = {i_left_imag[OP_W-1], i_left_imag} + {i_right_imag[OP_W-1], i_right_imag};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
        if (i_en) begin
            r1_cmd   <= t_cmd'(i_cmd);
            r1_p_rr  <= i_left_real * i_right_real;
            r1_p_ii  <= i_left_imag * i_right_imag;
            r1_p_ri  <= i_left_real * i_right_imag;
            r1_p_ir  <= i_left_imag * i_right_real;
            r1_p_lr  <= i_left_real * i_left_real;
            r1_p_li  <= i_left_imag * i_left_imag;
            r1_p_mr  <= i_right_real * i_right_real;
            r1_p_mi  <= i_right_imag * i_right_imag;
            r1_as_re <= n1_as_re;
            r1_as_im <= n1_as_im;
            r1_eq    <= (i_left_real == i_right_real) && (i_left_imag == i_right_imag);
        end
    end

    // stage 2: sums of products
    logic                    r2_valid;
    t_cmd                    r2_cmd;
    logic signed [SUM_W-1:0] r2_mul_re, r2_mul_im, r2_dn_re, r2_dn_im;
    logic [MAG_W-1:0]        r2_magl, r2_magr;
    logic signed [OP_W:0]    r2_as_re, r2_as_im;
    logic                    r2_eq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
        if (i_en) begin
            r2_cmd    <= r1_cmd;
            r2_mul_re <= SUM_W'(r1_p_rr) - SUM_W'(r1_p_ii);
            r2_mul_im <= SUM_W'(r1_p_ri) + SUM_W'(r1_p_ir);
            r2_dn_re  <= SUM_W'(r1_p_rr) + SUM_W'(r1_p_ii);
            r2_dn_im  <= SUM_W'(r1_p_ir) - SUM_W'(r1_p_ri);
            r2_magl   <= {1'b0, r1_p_lr[MAG_W-2:0]} + {1'b0, r1_p_li[MAG_W-2:0]};
            r2_magr   <= {1'b0, r1_p_mr[MAG_W-2:0]} + {1'b0, r1_p_mi[MAG_W-2:0]};
            r2_as_re  <= r1_as_re;
            r2_as_im  <= r1_as_im;
            r2_eq     <= r1_eq;
        end
    end

    // stage 3: finish non-divide commands, set up the divider
    t_div_state              n3_state;
    logic signed [SUM_W-1:0] sh_re, sh_im;
    logic [OP_W:0]           c_re, c_im;
    logic [MAG_W-1:0]        abs_re, abs_im;
    logic [NUM_W-1:0]        num_re, num_im;
    logic [CMP_W-1:0]        lim;

    always_comb begin
        sh_re  = r2_mul_re >>> FRAC_BITS;
        sh_im  = r2_mul_im >>> FRAC_BITS;
        abs_re = r2_dn_re[SUM_W-1] ? MAG_W'(-r2_dn_re) : MAG_W'(r2_dn_re);
        abs_im = r2_dn_im[SUM_W-1] ? MAG_W'(-r2_dn_im) : MAG_W'(r2_dn_im);
        num_re = {abs_re, {FRAC_BITS{1'b0}}};
        num_im = {abs_im, {FRAC_BITS{1'b0}}};
        lim    = {r2_magr, {QT_W{1'b0}}};
        c_re   = '0;
        c_im   = '0;

        n3_state             = '0;
        n3_state.side.is_div = (r2_cmd == CMD_DIV);
        n3_state.side.dz     = (r2_cmd == CMD_DIV) && (r2_magr == '0);
        n3_state.side.neg_re = r2_dn_re[SUM_W-1];
        n3_state.side.neg_im = r2_dn_im[SUM_W-1];
        n3_state.side.ovf_re = CMP_W'(num_re) >= lim;
        n3_state.side.ovf_im = CMP_W'(num_im) >= lim;
        n3_state.rem_re      = num_re;
        n3_state.rem_im      = num_im;
        n3_state.divisor     = r2_magr;

        case (r2_cmd)
            CMD_ADD, CMD_SUB: begin
                c_re = clamp_q(CLAMP_W'(r2_as_re));
                c_im = clamp_q(CLAMP_W'(r2_as_im));
            end
            CMD_MUL: begin
                c_re = clamp_q(CLAMP_W'(sh_re));
                c_im = clamp_q(CLAMP_W'(sh_im));
            end
            CMD_EQ:  n3_state.side.cmp = r2_eq;
            CMD_NE:  n3_state.side.cmp = !r2_eq;
            CMD_GT:  n3_state.side.cmp = r2_magl > r2_magr;
            CMD_LT:  n3_state.side.cmp = r2_magl < r2_magr;
            default: ;
        endcase
        n3_state.side.re  = c_re[OP_W-1:0];
        n3_state.side.im  = c_im[OP_W-1:0];
        n3_state.side.sat = c_re[OP_W] | c_im[OP_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r2_valid;
        end
        if (i_en) begin
            o_state <= n3_state;
        end
    end

endmodule

FILE: design/cna_div_step.sv
`timescale 1ns / 1ps

module cna_div_step (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic [cna_pkg::STEP_W-1:0]  i_bit,
    input  logic                        i_valid,
    input  cna_pkg::t_div_state         i_state,
    output logic                        o_valid,
    output cna_pkg::t_div_state         o_state
);
    import cna_pkg::*;

    t_div_state       n_state;
    logic [CMP_W-1:0] trial;
    logic [QT_W-1:0]  qbit;

    // one restoring step on each lane: subtract divisor << bit when it fits
    always_comb begin
        trial   = CMP_W'(i_state.divisor) << i_bit;
        qbit    = QT_W'(1) << i_bit;
        n_state = i_state;
        if (CMP_W'(i_state.rem_re) >= trial) begin
            n_state.rem_re = i_state.rem_re - trial[NUM_W-1:0];
            n_state.q_re   = i_state.q_re | qbit;
        end
        if (CMP_W'(i_state.rem_im) >= trial) begin
            n_state.rem_im = i_state.rem_im - trial[NUM_W-1:0];
            n_state.q_im   = i_state.q_im | qbit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
        if (i_en) begin
            o_state <= n_state;
        end
    end

endmodule

FILE: design/complex_number_alu_top.sv
`timescale 1ns / 1ps
// From input transfer to result on the output register, every command passes the same
// stages: 3 prep stages, 16 divider steps and 1 output stage.
// Throughput: one item per cycle; the pipeline advances as a whole whenever the
// output register is empty or its result is being taken.
// Reset (i_rst_n low, synchronous): clears all stage valid bits; payload is not reset.
module complex_number_alu_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [2:0]                      i_cmd,
    input  logic signed [cna_pkg::OP_W-1:0] i_left_real,
    input  logic signed [cna_pkg::OP_W-1:0] i_left_imag,
    input  logic signed [cna_pkg::OP_W-1:0] i_right_real,
    input  logic signed [cna_pkg::OP_W-1:0] i_right_imag,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic signed [cna_pkg::OP_W-1:0] o_result_real,
    output logic signed [cna_pkg::OP_W-1:0] o_result_imag,
    output logic                            o_compare_true,
    output logic                            o_divide_by_zero,
    output logic                            o_saturated
);
    import cna_pkg::*;

    // advance every stage together; hold all when the output result is stalled
    logic en;
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    // products, sums, non-divide results and divider setup
    logic       vld [QT_W+1];
    t_div_state st  [QT_W+1];

    cna_prep u_prep (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (i_valid),
        .i_cmd        (i_cmd),
        .i_left_real  (i_left_real),
        .i_left_imag  (i_left_imag),
        .i_right_real (i_right_real),
        .i_right_imag (i_right_imag),
        .o_valid      (vld[0]),
        .o_state      (st[0])
    );

    // restoring divider: one quotient bit per stage, most significant first
    for (genvar g = 0; g < QT_W; g++) begin : g_div
        cna_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_bit   (STEP_W'(QT_W - 1 - g)),
            .i_valid (vld[g]),
            .i_state (st[g]),
            .o_valid (vld[g+1]),
            .o_state (st[g+1])
        );
    end

    // quotient sign and saturation, then pick divide or carried result
    t_div_state      fin;
    logic [OP_W-1:0] d_re, d_im;
    logic            s_re, s_im;
    logic [OP_W-1:0] n_re, n_im;
    logic            n_cmp, n_dz, n_sat;
    logic [QT_W-1:0] q_min_mag;

    always_comb begin
        fin       = st[QT_W];
        q_min_mag = {1'b1, {(QT_W-1){1'b0}}};
        // positive: clamp above the top code; negative: clamp past the bottom code
        if (!fin.side.neg_re) begin
            s_re = fin.side.ovf_re || fin.q_re[QT_W-1];
            d_re = s_re ? {1'b0, {(OP_W-1){1'b1}}} : fin.q_re;
        end else begin
            s_re = fin.side.ovf_re || (fin.q_re > q_min_mag);
            d_re = s_re ? q_min_mag : OP_W'(-fin.q_re);
        end
        if (!fin.side.neg_im) begin
            s_im = fin.side.ovf_im || fin.q_im[QT_W-1];
            d_im = s_im ? {1'b0, {(OP_W-1){1'b1}}} : fin.q_im;
        end else begin
            s_im = fin.side.ovf_im || (fin.q_im > q_min_mag);
            d_im = s_im ? q_min_mag : OP_W'(-fin.q_im);
        end

        n_cmp = fin.side.cmp;
        n_dz  = fin.side.dz;
        if (fin.side.is_div) begin
            if (fin.side.dz) begin
                n_re  = '0;
                n_im  = '0;
                n_sat = 1'b0;
            end else begin
                n_re  = d_re;
                n_im  = d_im;
                n_sat = s_re | s_im;
            end
        end else begin
            n_re  = fin.side.re;
            n_im  = fin.side.im;
            n_sat = fin.side.sat;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= vld[QT_W];
        end
        if (en) begin
            o_result_real    <= n_re;
            o_result_imag    <= n_im;
            o_compare_true   <= n_cmp;
            o_divide_by_zero <= n_dz;
            o_saturated      <= n_sat;
        end
    end

`ifndef NO_ASSERTIONS
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_divide_by_zero |->
            o_result_real == '0 && o_result_imag == '0 && !o_saturated && !o_compare_true)
        else $error("divide by zero result not cleared");

    a_cmp_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_compare_true |->
            o_result_real == '0 && o_result_imag == '0 && !o_saturated)
        else $error("compare result carries arithmetic data");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !vld[0] && !vld[QT_W])
        else $error("valid bits survive reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(vld[QT_W]) && $stable(st[QT_W]))
        else $error("pipeline moved during output stall");
`endif

endmodule
